### hw/rtl/cdm_pkg.sv
// Shared types and constants for the constant-divisor remainder unit.
`default_nettype none

package cdm_pkg;

    localparam int OPND_W  = 32;    // operand and register width
    localparam int RES_W   = 33;    // signed remainder width
    localparam int WIDE_W  = 64;    // internal product / difference width
    localparam int SHIFT_W = 6;     // post shift amount
    localparam int IDX_W   = 2;     // config register index

    // Config register indexes
    localparam logic [IDX_W-1:0] CFG_DIVISOR = 2'd0;
    localparam logic [IDX_W-1:0] CFG_METHOD  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MULT    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SHIFT   = 2'd3;

    // Request function codes
    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;

    typedef enum logic [1:0] {
        METHOD_COMPARE = 2'd0,
        METHOD_MASK    = 2'd1,
        METHOD_MUL_FIX = 2'd2,
        METHOD_MUL     = 2'd3
    } method_t;

    typedef struct packed {
        logic [OPND_W-1:0]  divisor;
        method_t            method;
        logic [OPND_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [OPND_W-1:0] operand;
    } req_word_t;

    typedef struct packed {
        logic signed [RES_W-1:0] remainder;
        logic                    bad_request;
    } rsp_word_t;

    // Operand extended to 64 bits (sign or zero per func)
    typedef struct packed {
        logic              func;
        logic [WIDE_W-1:0] xe;
    } ext_word_t;

    typedef struct packed {
        logic              func;
        logic [WIDE_W-1:0] xe;
        logic [WIDE_W-1:0] p;
    } prod_word_t;

    typedef struct packed {
        logic              func;
        logic [WIDE_W-1:0] xe;
        logic [WIDE_W-1:0] q;
    } quot_word_t;

    typedef struct packed {
        logic              func;
        logic [WIDE_W-1:0] xe;
        logic [WIDE_W-1:0] pp0;
        logic [OPND_W-1:0] pp1;
    } part_word_t;

    typedef struct packed {
        logic              func;
        logic [WIDE_W-1:0] xe;
        logic [WIDE_W-1:0] v;
    } diff_word_t;

endpackage

`default_nettype wire

### hw/rtl/cdm_front.sv
// Front stages: operand capture and extension, then product x * c.
`default_nettype none

module cdm_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cdm_pkg::cfg_t         cfg,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire cdm_pkg::req_word_t    up_word,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output cdm_pkg::prod_word_t        dn_word
);

    localparam int EXT_W = cdm_pkg::WIDE_W - DATA_WIDTH;

    logic                  s1_valid_reg;
    cdm_pkg::ext_word_t    s1_reg, s1_next;
    logic                  s2_valid_reg;
    cdm_pkg::prod_word_t   s2_reg, s2_next;
    logic                  s1_open, s2_open;
    logic                  sign_bit;
    logic signed [2*cdm_pkg::RES_W-1:0] prod_full;

    // Stage advance: a stage loads when empty or when its word moves on
    always_comb
    begin
        s2_open  = !s2_valid_reg || !dn_stall;
        s1_open  = !s1_valid_reg || s2_open;
        up_stall = !s1_open;
    end

    // Stage 1 next: keep DATA_WIDTH bits, extend per func
    always_comb
    begin
        sign_bit      = (up_word.func == cdm_pkg::FUNC_SIGNED) && up_word.operand[DATA_WIDTH-1];
        s1_next.func  = up_word.func;
        s1_next.xe    = {{EXT_W{sign_bit}}, up_word.operand[DATA_WIDTH-1:0]};
    end

    // Stage 2 next: 33x33 signed product, exact in both modes
    always_comb
    begin
        prod_full    = $signed(s1_reg.xe[cdm_pkg::OPND_W:0]) * $signed({1'b0, cfg.mult});
        s2_next.func = s1_reg.func;
        s2_next.xe   = s1_reg.xe;
        s2_next.p    = prod_full[cdm_pkg::WIDE_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_open)
                s1_valid_reg <= up_valid;
            if (s2_open)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        if (s1_open)
            s1_reg <= s1_next;
        if (s2_open)
            s2_reg <= s2_next;
    end

    assign dn_valid = s2_valid_reg;
    assign dn_word  = s2_reg;

endmodule

`default_nettype wire

### hw/rtl/cdm_back.sv
// Middle stages: quotient shift, then quotient * divisor partial products.
`default_nettype none

module cdm_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cdm_pkg::cfg_t         cfg,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire cdm_pkg::prod_word_t   up_word,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output cdm_pkg::part_word_t        dn_word
);

    logic                  s3_valid_reg;
    cdm_pkg::quot_word_t   s3_reg, s3_next;
    logic                  s4_valid_reg;
    cdm_pkg::part_word_t   s4_reg, s4_next;
    logic                  s3_open, s4_open;
    logic signed [cdm_pkg::WIDE_W:0] shift_in;
    logic signed [cdm_pkg::WIDE_W:0] shift_out;

    always_comb
    begin
        s4_open  = !s4_valid_reg || !dn_stall;
        s3_open  = !s3_valid_reg || s4_open;
        up_stall = !s3_open;
    end

    // Stage 3 next: floor shift for signed words, logical for unsigned
    always_comb
    begin
        shift_in     = {(up_word.func == cdm_pkg::FUNC_SIGNED) && up_word.p[cdm_pkg::WIDE_W-1],
                        up_word.p};
        shift_out    = shift_in >>> cfg.shift;
        s3_next.func = up_word.func;
        s3_next.xe   = up_word.xe;
        s3_next.q    = shift_out[cdm_pkg::WIDE_W-1:0];
    end

    // Stage 4 next: q * d mod 2^64 as low and high partial products
    always_comb
    begin
        s4_next.func = s3_reg.func;
        s4_next.xe   = s3_reg.xe;
        s4_next.pp0  = 64'(s3_reg.q[cdm_pkg::OPND_W-1:0]) * 64'(cfg.divisor);
        s4_next.pp1  = s3_reg.q[cdm_pkg::WIDE_W-1:cdm_pkg::OPND_W] * cfg.divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_open)
                s3_valid_reg <= up_valid;
            if (s4_open)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_open)
            s3_reg <= s3_next;
        if (s4_open)
            s4_reg <= s4_next;
    end

    assign dn_valid = s4_valid_reg;
    assign dn_word  = s4_reg;

endmodule

`default_nettype wire

### hw/rtl/cdm_tail.sv
// Tail stages: x - q*d, then method select, correction and output register.
`default_nettype none

module cdm_tail (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cdm_pkg::cfg_t         cfg,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire cdm_pkg::part_word_t   up_word,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output cdm_pkg::rsp_word_t         dn_word
);

    logic                  s5_valid_reg;
    cdm_pkg::diff_word_t   s5_reg, s5_next;
    logic                  s6_valid_reg;
    cdm_pkg::rsp_word_t    s6_reg, s6_next;
    logic                  s5_open, s6_open;
    logic [cdm_pkg::OPND_W-1:0] x32;
    logic [cdm_pkg::OPND_W-1:0] v32;
    logic [cdm_pkg::OPND_W-1:0] r32;
    logic                       bad;

    always_comb
    begin
        s6_open  = !s6_valid_reg || !dn_stall;
        s5_open  = !s5_valid_reg || s6_open;
        up_stall = !s5_open;
    end

    // Stage 5 next: v = x - (pp0 + pp1 << 32), mod 2^64
    always_comb
    begin
        s5_next.func = up_word.func;
        s5_next.xe   = up_word.xe;
        s5_next.v    = up_word.xe - up_word.pp0 - {up_word.pp1, {cdm_pkg::OPND_W{1'b0}}};
    end

    // Stage 6 next: pick the method result
    always_comb
    begin
        x32 = s5_reg.xe[cdm_pkg::OPND_W-1:0];
        v32 = s5_reg.v[cdm_pkg::OPND_W-1:0];
        bad = (s5_reg.func == cdm_pkg::FUNC_SIGNED) &&
              (cfg.method inside {cdm_pkg::METHOD_COMPARE, cdm_pkg::METHOD_MASK});
        case (cfg.method)
            cdm_pkg::METHOD_COMPARE:
                r32 = (x32 >= cfg.divisor) ? (x32 - cfg.divisor) : x32;
            cdm_pkg::METHOD_MASK:
                r32 = x32 & (cfg.divisor - 32'd1);
            cdm_pkg::METHOD_MUL_FIX:
                // one correction add when the difference went negative
                r32 = (s5_reg.v[cdm_pkg::WIDE_W-1] && (s5_reg.func == cdm_pkg::FUNC_UNSIGNED))
                      ? (v32 + cfg.divisor) : v32;
            cdm_pkg::METHOD_MUL:
                r32 = v32;
            default:
                r32 = v32;
        endcase
        s6_next.bad_request = bad;
        if (bad)
            s6_next.remainder = '0;
        else if (s5_reg.func == cdm_pkg::FUNC_SIGNED)
            s6_next.remainder = {v32[cdm_pkg::OPND_W-1], v32};
        else
            s6_next.remainder = {1'b0, r32};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_open)
                s5_valid_reg <= up_valid;
            if (s6_open)
                s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_open)
            s5_reg <= s5_next;
        if (s6_open)
            s6_reg <= s6_next;
    end

    assign dn_valid = s6_valid_reg;
    assign dn_word  = s6_reg;

endmodule

`default_nettype wire

### hw/rtl/constant_divisor_modulo.sv
// Top level of the constant-divisor remainder unit: config registers and pipeline.
//
//  channel  dir  handshake             word
//  req      in   req_valid/req_stall   req_word  (func, operand)
//  rsp      out  rsp_valid/rsp_stall   rsp_word  (remainder, bad_request)
//  cfg      in   cfg_write             cfg_index, cfg_data
//
// One word per cycle sustained while rsp is not stalled; six register stages
// (extend, x*c, shift, q*d partials, subtract, select/correct).
// Each stage loads when empty or when its word moves on, so bubbles collapse
// and a stall on rsp backs up stage by stage without loss or repeat.
// Reset clears the valid bits and sets divisor 1, method compare, c 0, shift 0.
`default_nettype none

module constant_divisor_modulo #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire cdm_pkg::req_word_t           req_word,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output cdm_pkg::rsp_word_t                rsp_word,
    input  wire logic                         cfg_write,
    input  wire logic [cdm_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [cdm_pkg::OPND_W-1:0]   cfg_data
);

    cdm_pkg::cfg_t        cfg_reg;
    logic                 fb_valid, fb_stall;
    cdm_pkg::prod_word_t  fb_word;
    logic                 bt_valid, bt_stall;
    cdm_pkg::part_word_t  bt_word;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.divisor <= cdm_pkg::OPND_W'(1);
            cfg_reg.method  <= cdm_pkg::METHOD_COMPARE;
            cfg_reg.mult    <= '0;
            cfg_reg.shift   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cdm_pkg::CFG_DIVISOR: cfg_reg.divisor <= cfg_data;
                cdm_pkg::CFG_METHOD:  cfg_reg.method  <= cdm_pkg::method_t'(cfg_data[1:0]);
                cdm_pkg::CFG_MULT:    cfg_reg.mult    <= cfg_data;
                cdm_pkg::CFG_SHIFT:   cfg_reg.shift   <= cfg_data[cdm_pkg::SHIFT_W-1:0];
                default:              cfg_reg.shift   <= cfg_reg.shift;
            endcase
        end
    end

    cdm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (req_valid),
        .up_stall (req_stall),
        .up_word  (req_word),
        .dn_valid (fb_valid),
        .dn_stall (fb_stall),
        .dn_word  (fb_word)
    );

    cdm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (fb_valid),
        .up_stall (fb_stall),
        .up_word  (fb_word),
        .dn_valid (bt_valid),
        .dn_stall (bt_stall),
        .dn_word  (bt_word)
    );

    cdm_tail u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (bt_valid),
        .up_stall (bt_stall),
        .up_word  (bt_word),
        .dn_valid (rsp_valid),
        .dn_stall (rsp_stall),
        .dn_word  (rsp_word)
    );

endmodule

`default_nettype wire

### hw/rtl/cdm_port_check.sv
// Port-level checks for the constant-divisor remainder unit, bound to the top.
`default_nettype none

module cdm_port_check (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_stall,
    input  wire cdm_pkg::req_word_t   req_word,
    input  wire logic                 rsp_valid,
    input  wire logic                 rsp_stall,
    input  wire cdm_pkg::rsp_word_t   rsp_word
);

    // Held request word stays put
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
        else $error("request word changed while stalled");

    // Held response word stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("response word changed while stalled");

    // No response word during reset
    a_rst_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // Rejected signed request gives a zero remainder
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.bad_request |-> rsp_word.remainder == '0)
        else $error("bad request with nonzero remainder");

    // Remainder is a 32-bit value extended: top two bits agree when negative
    a_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.remainder[32] |-> rsp_word.remainder[31])
        else $error("remainder not a sign-extended 32-bit value");

endmodule

bind constant_divisor_modulo cdm_port_check u_port_check (.*);

`default_nettype wire

### tb/constant_divisor_modulo_tb.sv
// Self-checking testbench for constant_divisor_modulo: directed table, then random words.
`timescale 1ns / 1ps

module constant_divisor_modulo_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;      // pipeline is six stages deep
    localparam int PHASE_WORDS  = 490;     // three idle phases, about 1550 words

    localparam logic FN_UNSIGNED = cdm_pkg::FUNC_UNSIGNED;
    localparam logic FN_SIGNED   = cdm_pkg::FUNC_SIGNED;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One directed step: a config setting or a request word with optional typed result
    typedef struct {
        row_kind_t           kind;
        cdm_pkg::req_word_t  word;
        logic                known;
        cdm_pkg::rsp_word_t  result;
        cdm_pkg::cfg_t       cfg;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b1;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    cdm_pkg::req_word_t            req_word = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    cdm_pkg::rsp_word_t            rsp_word;
    logic                          cfg_write = 1'b0;
    logic [cdm_pkg::IDX_W-1:0]     cfg_index = cdm_pkg::CFG_DIVISOR;
    logic [cdm_pkg::OPND_W-1:0]    cfg_data = '0;

    // Sideband riding along with req_word: typed result for directed rows
    logic                          word_known = 1'b0;
    cdm_pkg::rsp_word_t            word_result = '0;

    cdm_pkg::cfg_t                 cfg_shadow;
    cdm_pkg::rsp_word_t            pending_remainders[$];
    cdm_pkg::rsp_word_t            oldest;
    stim_row_t                     directed[$];
    int                            mismatches = 0;
    int                            cycle_count = 0;
    int                            send_idle_pct = 25;
    int                            recv_stall_pct = 52;

    constant_divisor_modulo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Remainder the datapath should give for one request under a setting
    function automatic cdm_pkg::rsp_word_t remainder_of(cdm_pkg::cfg_t c,
                                                        cdm_pkg::req_word_t w);
        cdm_pkg::rsp_word_t r;
        logic [63:0]       x;
        logic [63:0]       d;
        logic [63:0]       m;
        logic [63:0]       q;
        logic [63:0]       v;
        logic signed [63:0] p;
        r = '0;
        d = 64'(c.divisor);
        m = 64'(c.mult);
        if (w.func == cdm_pkg::FUNC_UNSIGNED)
        begin
            x = 64'(w.operand);
            case (c.method)
                cdm_pkg::METHOD_COMPARE: v = (x >= d) ? x - d : x;
                cdm_pkg::METHOD_MASK:    v = x & (d - 64'd1);
                default:
                begin
                    q = (x * m) >> c.shift;
                    v = x - q * d;
                    // one correction add when the quotient overshoots
                    if (c.method == cdm_pkg::METHOD_MUL_FIX && v[63])
                        v = v + d;
                end
            endcase
            r.remainder = {1'b0, v[31:0]};
        end
        else if (c.method == cdm_pkg::METHOD_COMPARE || c.method == cdm_pkg::METHOD_MASK)
        begin
            r.bad_request = 1'b1;
        end
        else
        begin
            // floor quotient from an arithmetic shift of the signed product
            x = {{32{w.operand[31]}}, w.operand};
            p = x * m;
            q = p >>> c.shift;
            v = x - q * d;
            r.remainder = {v[31], v[31:0]};
        end
        return r;
    endfunction

    function automatic stim_row_t word_row(logic f, logic [cdm_pkg::OPND_W-1:0] op);
        stim_row_t row;
        row = '{ROW_WORD, '{f, op}, 1'b0, '0, '0};
        return row;
    endfunction

    function automatic stim_row_t known_row(logic f, logic [cdm_pkg::OPND_W-1:0] op,
                                            logic [cdm_pkg::RES_W-1:0] rem, logic bad);
        stim_row_t row;
        row = '{ROW_WORD, '{f, op}, 1'b1, '{rem, bad}, '0};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [cdm_pkg::OPND_W-1:0] div,
                                          cdm_pkg::method_t meth,
                                          logic [cdm_pkg::OPND_W-1:0] mult,
                                          logic [cdm_pkg::SHIFT_W-1:0] sh);
        stim_row_t row;
        row = '{ROW_CFG, '0, 1'b0, '0, '{div, meth, mult, sh}};
        return row;
    endfunction

    // Random setting: mostly the constants software would pick for the method
    function automatic cdm_pkg::cfg_t random_setting();
        cdm_pkg::cfg_t c;
        int            pick;
        int            l;
        logic [63:0]   d;
        pick = $urandom_range(0, 9);
        c.method = cdm_pkg::method_t'($urandom_range(0, 3));
        c.mult = $urandom;
        c.shift = cdm_pkg::SHIFT_W'($urandom_range(0, 63));
        case (c.method)
            cdm_pkg::METHOD_COMPARE:
                c.divisor = (pick < 8) ? ($urandom | 32'h8000_0000) : $urandom;
            cdm_pkg::METHOD_MASK:
                c.divisor = (pick < 8) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
            default:
            begin
                c.divisor = (pick < 5) ? $urandom_range(1, 1000)
                          : (pick < 9) ? $urandom : 32'd0;
                // reciprocal c = ceil(2^a / d) with a = 31 + ceil(log2 d)
                if (c.divisor != 0 && pick != 8)
                begin
                    d = 64'(c.divisor);
                    l = 0;
                    while ((64'd1 << l) < d)
                        l++;
                    c.shift = cdm_pkg::SHIFT_W'(31 + l);
                    c.mult = cdm_pkg::OPND_W'(((64'd1 << (31 + l)) + d - 64'd1) / d);
                end
            end
        endcase
        return c;
    endfunction

    // Operands biased toward the corners and toward multiples of d
    function automatic logic [cdm_pkg::OPND_W-1:0] random_operand(
        logic [cdm_pkg::OPND_W-1:0] d);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2:       return 32'h8000_0000 + $urandom_range(0, 15) - 32'd8;
            3:       return d * $urandom_range(0, 50) + $urandom_range(0, 2) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Send one request word, with a random idle gap in front of it
    task automatic send_word(input cdm_pkg::req_word_t w, input logic known,
                             input cdm_pkg::rsp_word_t res);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_word    <= w;
        word_known  <= known;
        word_result <= res;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Wait until every word is back, then write all four registers
    task automatic set_config(input cdm_pkg::cfg_t c);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_remainders.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= cdm_pkg::CFG_DIVISOR;
        cfg_data  <= c.divisor;
        @(posedge clk);
        cfg_index <= cdm_pkg::CFG_METHOD;
        cfg_data  <= cdm_pkg::OPND_W'(c.method);
        @(posedge clk);
        cfg_index <= cdm_pkg::CFG_MULT;
        cfg_data  <= c.mult;
        @(posedge clk);
        cfg_index <= cdm_pkg::CFG_SHIFT;
        cfg_data  <= cdm_pkg::OPND_W'(c.shift);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Receiver stalls
    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Register shadow, expected remainders, and result checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_shadow <= '{32'd1, cdm_pkg::METHOD_COMPARE, 32'd0, 6'd0};
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    cdm_pkg::CFG_DIVISOR: cfg_shadow.divisor <= cfg_data;
                    cdm_pkg::CFG_METHOD:
                        cfg_shadow.method <= cdm_pkg::method_t'(cfg_data[1:0]);
                    cdm_pkg::CFG_MULT:    cfg_shadow.mult    <= cfg_data;
                    cdm_pkg::CFG_SHIFT:
                        cfg_shadow.shift <= cfg_data[cdm_pkg::SHIFT_W-1:0];
                    default:              ;
                endcase
            end
            if (req_valid && !req_stall)
                pending_remainders.push_back(word_known ? word_result
                                                        : remainder_of(cfg_shadow, req_word));
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_remainders.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: rem %h bad %b",
                                 rsp_word.remainder, rsp_word.bad_request);
                end
                else
                begin
                    oldest = pending_remainders.pop_front();
                    if (rsp_word.remainder !== oldest.remainder ||
                        rsp_word.bad_request !== oldest.bad_request)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected rem %h bad %b, got rem %h bad %b",
                                     oldest.remainder, oldest.bad_request,
                                     rsp_word.remainder, rsp_word.bad_request);
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL constant_divisor_modulo");
            $finish;
        end
    end

    initial
    begin
        int                 sent;
        int                 burst;
        cdm_pkg::req_word_t w;

        // falling edge at time zero so the asynchronous reset takes hold at once
        rst_n <= 1'b0;

        // reset defaults: d = 1, compare-subtract
        directed.push_back(known_row(FN_UNSIGNED, 32'h0000_0000, 33'h0_0000_0000, 1'b0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hFFFF_FFFF, 33'h0_FFFF_FFFE, 1'b0));
        directed.push_back(known_row(FN_SIGNED,   32'h8000_0000, 33'h0_0000_0000, 1'b1));
        // compare with d just over half range
        directed.push_back(cfg_row(32'h8000_0001, cdm_pkg::METHOD_COMPARE, 32'h0, 6'd0));
        directed.push_back(known_row(FN_UNSIGNED, 32'h8000_0000, 33'h0_8000_0000, 1'b0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hFFFF_FFFF, 33'h0_7FFF_FFFE, 1'b0));
        directed.push_back(known_row(FN_UNSIGNED, 32'h8000_0001, 33'h0_0000_0000, 1'b0));
        // divisor zero under compare: nothing is subtracted
        directed.push_back(cfg_row(32'h0, cdm_pkg::METHOD_COMPARE, 32'hFFFF_FFFF, 6'd63));
        directed.push_back(known_row(FN_UNSIGNED, 32'h1234_5678, 33'h0_1234_5678, 1'b0));
        directed.push_back(known_row(FN_SIGNED,   32'hFFFF_FFFF, 33'h0_0000_0000, 1'b1));
        // mask with a power of two
        directed.push_back(cfg_row(32'd16, cdm_pkg::METHOD_MASK, 32'h0, 6'd0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hFFFF_FFFF, 33'h0_0000_000F, 1'b0));
        directed.push_back(known_row(FN_SIGNED,   32'h0000_0005, 33'h0_0000_0000, 1'b1));
        // mask with a divisor that is not a power of two
        directed.push_back(cfg_row(32'd12, cdm_pkg::METHOD_MASK, 32'h0, 6'd0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hFFFF_FFFF, 33'h0_0000_000B, 1'b0));
        // mask with divisor zero: all ones
        directed.push_back(cfg_row(32'h0, cdm_pkg::METHOD_MASK, 32'h0, 6'd0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hDEAD_BEEF, 33'h0_DEAD_BEEF, 1'b0));
        // multiply with correction, d = 7
        directed.push_back(cfg_row(32'd7, cdm_pkg::METHOD_MUL_FIX, 32'h9249_2492, 6'd34));
        directed.push_back(word_row(FN_UNSIGNED, 32'h0000_0000));
        directed.push_back(word_row(FN_UNSIGNED, 32'hFFFF_FFFF));
        directed.push_back(word_row(FN_SIGNED,   32'h8000_0000));
        directed.push_back(word_row(FN_SIGNED,   32'hFFFF_FFFF));
        directed.push_back(word_row(FN_SIGNED,   32'h7FFF_FFFF));
        // plain multiply, d = 10
        directed.push_back(cfg_row(32'd10, cdm_pkg::METHOD_MUL, 32'hCCCC_CCCD, 6'd35));
        directed.push_back(word_row(FN_UNSIGNED, 32'hFFFF_FFFF));
        directed.push_back(word_row(FN_UNSIGNED, 32'h0000_0000));
        directed.push_back(word_row(FN_SIGNED,   32'h8000_0000));
        directed.push_back(word_row(FN_SIGNED,   32'hFFFF_FFF6));
        // every constant at its top value
        directed.push_back(cfg_row(32'hFFFF_FFFF, cdm_pkg::METHOD_MUL, 32'hFFFF_FFFF, 6'd63));
        directed.push_back(word_row(FN_UNSIGNED, 32'hFFFF_FFFF));
        directed.push_back(word_row(FN_SIGNED,   32'h8000_0000));
        // zero multiplier: quotient zero, remainder is the operand
        directed.push_back(cfg_row(32'd1, cdm_pkg::METHOD_MUL_FIX, 32'h0, 6'd0));
        directed.push_back(known_row(FN_UNSIGNED, 32'hAAAA_AAAA, 33'h0_AAAA_AAAA, 1'b0));
        directed.push_back(known_row(FN_SIGNED,   32'h8000_0000, 33'h1_8000_0000, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                set_config(directed[i].cfg);
            else
                send_word(directed[i].word, directed[i].known, directed[i].result);
        end

        // random words: receiver-heavy stalls, sender-heavy idling, then full rate
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 52 : 0;
            recv_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 25 : 0;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                set_config(random_setting());
                burst = $urandom_range(20, 80);
                repeat (burst)
                begin
                    w.func    = 1'($urandom_range(0, 1));
                    w.operand = random_operand(cfg_shadow.divisor);
                    send_word(w, 1'b0, '0);
                end
                sent += burst;
            end
        end

        // drain
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_remainders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS constant_divisor_modulo");
        else
            $display("FAIL constant_divisor_modulo");
        $finish;
    end

endmodule
